>>> sv/ffsa_pkg.sv
// Shared types and constants of the first-fit segment allocator.
package ffsa_pkg;

  localparam int TABLE_ENTRIES = 128;
  localparam int IDX_W   = $clog2(TABLE_ENTRIES);
  localparam int CNT_W   = $clog2(TABLE_ENTRIES + 1);
  localparam int START_W = 7;
  localparam int SIZE_W  = 8;

  localparam logic [CNT_W-1:0] TABLE_FULL_COUNT = CNT_W'(TABLE_ENTRIES);

  localparam logic [1:0] STATUS_LOADED    = 2'd0;
  localparam logic [1:0] STATUS_ALLOCATED = 2'd1;
  localparam logic [1:0] STATUS_NOFIT     = 2'd2;
  localparam logic [1:0] STATUS_FULL      = 2'd3;

  localparam logic MODE_LOAD     = 1'b0;
  localparam logic MODE_ALLOCATE = 1'b1;

  typedef struct packed {
    logic               mode;
    logic               load_free;
    logic [START_W-1:0] load_start;
    logic [SIZE_W-1:0]  load_size;
    logic [SIZE_W-1:0]  request_size;
  } cmd_t;

  typedef struct packed {
    logic [1:0]         result_status;
    logic [6:0]         entry_index;
    logic [START_W-1:0] entry_start;
    logic [SIZE_W-1:0]  previous_size;
  } result_t;

  // One table entry as stored in the segment memory.
  typedef struct packed {
    logic               free;
    logic [START_W-1:0] start;
    logic [SIZE_W-1:0]  size;
  } seg_t;

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    seg_t             wdata;
    logic [IDX_W-1:0] raddr;
  } ram_req_t;

endpackage

>>> sv/ffsa_seg_ram.sv
// Segment table memory: one write port, one read port, registered read data.
module ffsa_seg_ram (
  input  logic              clk,
  input  ffsa_pkg::ram_req_t req,
  output ffsa_pkg::seg_t    rdata
);

  ffsa_pkg::seg_t mem [ffsa_pkg::TABLE_ENTRIES];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    rdata <= mem[req.raddr];
  end

endmodule

>>> sv/first_fit_segment_allocator_top.sv
// Top level of the first-fit segment allocator: command sequencer and count.
//
// A command is taken on a clock edge with start high and busy low. A load
// command appends one segment (or reports table full) and its result appears
// on the next cycle; busy stays low, so a new command may follow at once. An
// allocate command reads the segment memory one entry per cycle from index 0
// and stops at the first free entry whose size covers the request, or after
// the last loaded entry; busy is high until then. The memory's single read
// port sets that rate. An empty table reports no fit on the next cycle.
// Every result is a one-cycle beat marked by done; the receiver cannot
// stall it, so it must take each beat as shown. The table holds no reset
// pass: only the state, the fill count and done are cleared.
module first_fit_segment_allocator_top (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  ffsa_pkg::cmd_t    cmd,
  output logic              done,
  output ffsa_pkg::result_t result
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_SCAN = 1'b1;

  logic                           state;
  logic [ffsa_pkg::CNT_W-1:0]     count;
  logic [ffsa_pkg::IDX_W-1:0]     ptr;      // entry whose data is on rdata
  logic [ffsa_pkg::SIZE_W-1:0]    req_size;

  ffsa_pkg::ram_req_t ram_req;
  ffsa_pkg::seg_t     rdata;

  logic accept;
  logic fits;
  logic last;
  logic done_next;

  ffsa_seg_ram u_ram (
    .clk   (clk),
    .req   (ram_req),
    .rdata (rdata)
  );

  assign busy   = (state == ST_SCAN);
  assign accept = start && !busy;
  assign fits   = rdata.free && (req_size <= rdata.size);
  assign last   = ((ffsa_pkg::CNT_W'(ptr) + 1'b1) == count);

  // A beat goes out after a load, after an allocate on an empty table, and at
  // the end of a scan (hit or last entry searched).
  assign done_next = (state == ST_IDLE) ?
                     (accept && (cmd.mode == ffsa_pkg::MODE_LOAD || count == '0)) :
                     (fits || last);

  // Memory port: loads write in idle; the scan reads ahead one entry and
  // writes back the chosen entry. In the scan a write and a read never hit the
  // same entry in one cycle, and the next command's first read follows that write.
  always_comb begin
    ram_req.we    = 1'b0;
    ram_req.waddr = count[ffsa_pkg::IDX_W-1:0];
    ram_req.wdata = '{free: cmd.load_free, start: cmd.load_start, size: cmd.load_size};
    ram_req.raddr = '0;
    if (state == ST_IDLE) begin
      if (accept && cmd.mode == ffsa_pkg::MODE_LOAD && count != ffsa_pkg::TABLE_FULL_COUNT) begin
        ram_req.we = 1'b1;
      end
    end else begin
      ram_req.raddr = ptr + 1'b1;
      ram_req.waddr = ptr;
      ram_req.wdata = '{free: 1'b0, start: rdata.start, size: req_size};
      ram_req.we    = fits;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      count <= '0;
      done  <= 1'b0;
    end else begin
      done <= done_next;
      case (state)
        ST_IDLE: begin
          if (accept) begin
            req_size <= cmd.request_size;
            ptr      <= '0;
            if (cmd.mode == ffsa_pkg::MODE_LOAD) begin
              if (count == ffsa_pkg::TABLE_FULL_COUNT) begin
                result <= '{ffsa_pkg::STATUS_FULL, '0, '0, '0};
              end else begin
                result <= '{ffsa_pkg::STATUS_LOADED, 7'(count), cmd.load_start, '0};
                count  <= count + 1'b1;
              end
            end else if (count == '0) begin
              result <= '{ffsa_pkg::STATUS_NOFIT, '0, '0, '0};
            end else begin
              state <= ST_SCAN;
            end
          end
        end
        ST_SCAN: begin
          if (fits) begin
            result <= '{ffsa_pkg::STATUS_ALLOCATED, 7'(ptr), rdata.start, rdata.size};
            state  <= ST_IDLE;
          end else if (last) begin
            result <= '{ffsa_pkg::STATUS_NOFIT, '0, '0, '0};
            state  <= ST_IDLE;
          end else begin
            ptr <= ptr + 1'b1;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule
